/* hw/rtl/xtea_pkg.sv */
// XTEA cipher package: payload structs, pipeline stage types and round constants.
// Used by xtea_cell and xtea_block_cipher_top; depends on nothing else.

package xtea_pkg;

   localparam int unsigned NUM_ROUNDS = 32;
   localparam int unsigned NUM_STAGES = 2 * NUM_ROUNDS;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned NUM_KEYS   = 4;
   localparam int unsigned CSR_IDX_W  = $clog2(NUM_KEYS);

   localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic              op;
      logic [WORD_W-1:0] block_word0;
      logic [WORD_W-1:0] block_word1;
   } req_data_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_word0;
      logic [WORD_W-1:0] result_word1;
   } rsp_data_type;

   typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_array_type;

   // one half-round's worth of data travelling down the chain
   typedef struct packed {
      logic              vld;
      logic              op;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
   } stage_type;

   // fixed per-cell settings, worked out at elaboration
   typedef struct packed {
      logic [WORD_W-1:0] sum_enc;
      logic [WORD_W-1:0] sum_dec;
      logic              odd_half;
   } cell_cfg_type;

   // round sum seen by half-round s; (s+1)/2 rounds of delta have been added
   function automatic logic [WORD_W-1:0] enc_sum(input int unsigned s);
      logic [WORD_W-1:0] n;
      n = WORD_W'((s + 1) >> 1);
      return n * DELTA;
   endfunction

   function automatic logic [WORD_W-1:0] dec_sum(input int unsigned s);
      logic [WORD_W-1:0] n;
      n = WORD_W'(NUM_ROUNDS - ((s + 1) >> 1));
      return n * DELTA;
   endfunction

   function automatic cell_cfg_type cell_cfg(input int unsigned s);
      cell_cfg_type c;
      c.sum_enc  = enc_sum(s);
      c.sum_dec  = dec_sum(s);
      c.odd_half = s[0];
      return c;
   endfunction

endpackage

/* hw/rtl/xtea_block_cipher_top.sv */
// XTEA block cipher top level: key registers, chain of half-round cells, output skid queue.
// Depends on xtea_pkg and xtea_cell.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_data  (op, block_word0, block_word1)
//   rsp      out  rsp_valid / rsp_stall  rsp_data  (result_word0, result_word1)
//   csr      in   csr_wen                csr_index, csr_wdata (key words 0..3)
//
// One item per cycle sustained unless req_stall holds the chain; each item passes
// 2*NUM_ROUNDS half-round cells, each registered, and then enters the output queue.
// The two-entry output queue lets the chain keep moving while one result waits;
// req_stall rises only when both entries are full, and then the whole chain holds.
// Reset is synchronous and clears the valid bits, the queue count and the key.

module xtea_block_cipher_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  xtea_pkg::req_data_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output xtea_pkg::rsp_data_type          rsp_data,
   input  logic                            csr_wen,
   input  logic [xtea_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [xtea_pkg::WORD_W-1:0]     csr_wdata
);

   xtea_pkg::key_array_type key_ff;
   xtea_pkg::stage_type     stg [xtea_pkg::NUM_STAGES+1];
   xtea_pkg::stage_type     last;
   xtea_pkg::rsp_data_type  head_ff, head_in;
   xtea_pkg::rsp_data_type  skid_ff, skid_in;
   xtea_pkg::rsp_data_type  push_data;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    en;
   logic                    push;
   logic                    pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wen) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   assign en = (cnt_ff != 2'd2);
   assign req_stall = !en;

   assign stg[0] = {req_valid, req_data.op, req_data.block_word0, req_data.block_word1};

   for (genvar i = 0; i < xtea_pkg::NUM_STAGES; i++) begin : g_cell
      xtea_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .cfg     (xtea_pkg::cell_cfg(i)),
         .key     (key_ff),
         .stg_in  (stg[i]),
         .stg_out (stg[i+1])
      );
   end

   assign last = stg[xtea_pkg::NUM_STAGES];

   // output queue: head is what rsp shows, skid catches one more item
   always_comb begin
      push = en && last.vld;
      pop  = (cnt_ff != 2'd0) && !rsp_stall;
      push_data.result_word0 = last.y;
      push_data.result_word1 = last.z;
      head_in = head_ff;
      skid_in = skid_ff;
      cnt_in  = cnt_ff;
      case ({push, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               skid_in = push_data;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            head_in = skid_ff;
            cnt_in  = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = skid_ff;
               skid_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = head_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(last.vld && cnt_ff == 2'd2 && en))
      else $error("push into full output queue");

   a_enter_chain: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> stg[1].vld)
      else $error("accepted item missing from first cell");

   a_hold_chain: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(last.vld) && $stable(last.y) && $stable(last.z))
      else $error("chain moved while held");

endmodule

/* hw/rtl/xtea_cell.sv */
// One XTEA half-round cell of the pipeline chain, registered at its output.
// Depends on xtea_pkg.

module xtea_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  xtea_pkg::cell_cfg_type cfg,
   input  xtea_pkg::key_array_type key,
   input  xtea_pkg::stage_type    stg_in,
   output xtea_pkg::stage_type    stg_out
);

   xtea_pkg::stage_type          stg_ff;
   xtea_pkg::stage_type          stg_in_d;
   logic                         dec;
   logic                         upd_y;
   logic [xtea_pkg::WORD_W-1:0]  src;
   logic [xtea_pkg::WORD_W-1:0]  tgt;
   logic [xtea_pkg::WORD_W-1:0]  sum;
   logic [xtea_pkg::WORD_W-1:0]  mix;
   logic [xtea_pkg::WORD_W-1:0]  f;
   logic [xtea_pkg::WORD_W-1:0]  res;
   logic [xtea_pkg::CSR_IDX_W-1:0] kidx;

   always_comb begin
      dec   = (stg_in.op == xtea_pkg::OP_DECRYPT);
      // encrypt updates y first, decrypt updates z first
      upd_y = dec ? cfg.odd_half : !cfg.odd_half;
      src   = upd_y ? stg_in.z : stg_in.y;
      tgt   = upd_y ? stg_in.y : stg_in.z;
      sum   = dec ? cfg.sum_dec : cfg.sum_enc;
      kidx  = upd_y ? sum[1:0] : sum[12:11];
      mix   = ((src << 4) ^ (src >> 5)) + src;
      f     = mix ^ (sum + key[kidx]);
      res   = dec ? (tgt - f) : (tgt + f);

      stg_in_d     = stg_in;
      if (upd_y) begin
         stg_in_d.y = res;
      end else begin
         stg_in_d.z = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff.vld <= 1'b0;
      end else if (en) begin
         stg_ff.vld <= stg_in.vld;
      end
      if (en) begin
         stg_ff.op <= stg_in_d.op;
         stg_ff.y  <= stg_in_d.y;
         stg_ff.z  <= stg_in_d.z;
      end
   end

   assign stg_out = stg_ff;

endmodule
